@@ rtl/gap_filled_speed_estimator_unit_defines.svh @@
// Assertion macros for the checker file of the speed estimator.
`ifndef GAP_FILLED_SPEED_ESTIMATOR_UNIT_DEFINES_SVH
`define GAP_FILLED_SPEED_ESTIMATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GFSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GFSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gfse_pkg.sv @@
// Types and constants of the gap-filled speed estimator.
package gfse_pkg;

    localparam int POS_W     = 13;
    localparam int SCALE_W   = 24;
    localparam int RATE_W    = 10;
    localparam int SPEED_W   = 32;
    localparam int GAP_W     = 6;
    localparam int RUN_W     = GAP_W + 1;
    localparam int DIV_W     = GAP_W + 1;
    localparam int PROD1_W   = POS_W + SCALE_W;
    localparam int PROD_W    = PROD1_W + RATE_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = SCALE_W;

    localparam logic [GAP_W-1:0]   MAX_GAP     = 6'd63;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
    localparam logic [RATE_W-1:0]  RATE_RESET  = 10'd25;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE  = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } top_state_t;

    typedef enum logic [2:0] {
        AR_IDLE,
        AR_MUL1,
        AR_MUL2,
        AR_DIV,
        AR_DONE
    } arith_state_t;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] diff;
        logic [DIV_W-1:0] divisor;
    } arith_req_t;

    typedef struct packed {
        logic               done;
        logic [SPEED_W-1:0] quotient;
    } arith_rsp_t;

endpackage

@@ rtl/gap_filled_speed_estimator_unit.sv @@
// Top level of the gap-filled speed estimator: sequencer, state and result run.
// A present frame goes from its transaction to the first result through two
//   multiply steps, 47 divide steps in the shared divider and the handoff.
// Throughput: a run of N results then leaves at one per cycle without stall;
//   the next frame is taken in the cycle after the last result of the run.
// Reset (rst_n low, asynchronous) clears reference and gap count and restores
//   pixel_scale to 65536 (1.0 m/pixel) and frame_rate to 25.
module gap_filled_speed_estimator_unit
    import gfse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // frame channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [POS_W-1:0]     position,
    input  logic                 present,
    input  logic                 series_end,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SPEED_W-1:0]   speed_value,
    output logic                 has_speed,
    output logic                 run_last,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    top_state_t          state_reg, state_next;

    logic [SCALE_W-1:0]  pixel_scale_reg;
    logic [RATE_W-1:0]   frame_rate_reg;

    // Tracking state kept between frames
    logic [POS_W-1:0]    ref_pos_reg, ref_pos_next;
    logic                ref_valid_reg, ref_valid_next;
    logic [GAP_W-1:0]    missing_reg, missing_next;

    // Pending run of results
    logic [RUN_W-1:0]    emit_count_reg, emit_count_next;
    logic [SPEED_W-1:0]  emit_speed_reg, emit_speed_next;
    logic                emit_has_reg, emit_has_next;

    logic                in_accept;
    logic                out_accept;
    logic                gap_full;
    logic [RUN_W-1:0]    missing_plus1;
    logic [POS_W-1:0]    abs_diff;

    arith_req_t          req;
    arith_rsp_t          rsp;

    assign in_accept     = in_valid && !in_stall;
    assign out_accept    = out_valid && !out_stall;
    assign gap_full      = (missing_reg >= MAX_GAP);
    assign missing_plus1 = RUN_W'(missing_reg) + RUN_W'(1);
    assign abs_diff      = (position >= ref_pos_reg) ? (position - ref_pos_reg)
                                                     : (ref_pos_reg - position);

    // Divider request: distance is zero without a reference
    always_comb
    begin
        req.start   = in_accept && present;
        req.diff    = ref_valid_reg ? abs_diff : '0;
        req.divisor = missing_plus1;
    end

    gfse_arith u_arith (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .pixel_scale (pixel_scale_reg),
        .frame_rate  (frame_rate_reg),
        .rsp         (rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (present)
                        state_next = ST_CALC;
                    else if (gap_full || series_end)
                        state_next = ST_EMIT;
                end
            end
            ST_CALC: if (rsp.done) state_next = ST_EMIT;
            ST_EMIT: if (out_accept && emit_count_reg == RUN_W'(1)) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs follow the state alone
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_EMIT);
    end

    assign speed_value = emit_speed_reg;
    assign has_speed   = emit_has_reg;
    assign run_last    = (emit_count_reg == RUN_W'(1));

    // Frame bookkeeping and run setup
    always_comb
    begin
        ref_pos_next    = ref_pos_reg;
        ref_valid_next  = ref_valid_reg;
        missing_next    = missing_reg;
        emit_count_next = emit_count_reg;
        emit_speed_next = emit_speed_reg;
        emit_has_next   = emit_has_reg;

        if (in_accept)
        begin
            if (present)
            begin
                // speed for every pending frame plus this one
                emit_count_next = missing_plus1;
                emit_has_next   = 1'b1;
                ref_pos_next    = position;
                ref_valid_next  = 1'b1;
                missing_next    = '0;
            end
            else if (gap_full)
            begin
                // gap overflow: drop the reference, flush without speed
                emit_count_next = missing_plus1;
                emit_has_next   = 1'b0;
                emit_speed_next = '0;
                missing_next    = '0;
                ref_valid_next  = 1'b0;
            end
            else
            begin
                missing_next = missing_plus1[GAP_W-1:0];
                if (series_end)
                begin
                    emit_count_next = missing_plus1;
                    emit_has_next   = 1'b0;
                    emit_speed_next = '0;
                end
            end

            // series end: forget the reference after the frame itself
            if (series_end)
            begin
                ref_valid_next = 1'b0;
                ref_pos_next   = '0;
                missing_next   = '0;
            end
        end

        if (state_reg == ST_CALC && rsp.done)
            emit_speed_next = rsp.quotient;

        if (out_accept)
            emit_count_next = emit_count_reg - RUN_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ref_pos_reg    <= '0;
            ref_valid_reg  <= 1'b0;
            missing_reg    <= '0;
            emit_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ref_pos_reg    <= ref_pos_next;
            ref_valid_reg  <= ref_valid_next;
            missing_reg    <= missing_next;
            emit_count_reg <= emit_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        emit_speed_reg <= emit_speed_next;
        emit_has_reg   <= emit_has_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_scale_reg <= SCALE_RESET;
            frame_rate_reg  <= RATE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PIXEL_SCALE: pixel_scale_reg <= cfg_data[SCALE_W-1:0];
                CFG_FRAME_RATE:  frame_rate_reg  <= cfg_data[RATE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ rtl/gfse_arith.sv @@
// Shared arithmetic unit: two multiply steps, then a bit-serial restoring divide.
module gfse_arith
    import gfse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  arith_req_t         req,
    input  logic [SCALE_W-1:0] pixel_scale,
    input  logic [RATE_W-1:0]  frame_rate,
    output arith_rsp_t         rsp
);

    arith_state_t        state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [POS_W-1:0]    diff_reg, diff_next;
    logic [DIV_W-1:0]    divisor_reg, divisor_next;
    logic [PROD_W-1:0]   work_reg, work_next;
    logic [GAP_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    trial;
    logic                qbit;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            AR_IDLE: if (req.start) state_next = AR_MUL1;
            AR_MUL1: state_next = AR_MUL2;
            AR_MUL2: state_next = AR_DIV;
            AR_DIV:  if (step_reg == '0) state_next = AR_DONE;
            AR_DONE: state_next = AR_IDLE;
            default: state_next = AR_IDLE;
        endcase
    end

    // Divide step: shift in one dividend bit, subtract when it fits
    assign trial = {rem_reg, work_reg[PROD_W-1]};
    assign qbit  = (trial >= divisor_reg);

    always_comb
    begin
        step_next    = step_reg;
        diff_next    = diff_reg;
        divisor_next = divisor_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        case (state_reg)
            AR_IDLE:
            begin
                if (req.start)
                begin
                    diff_next    = req.diff;
                    divisor_next = req.divisor;
                end
            end
            AR_MUL1:
            begin
                work_next = PROD_W'(PROD1_W'(diff_reg) * PROD1_W'(pixel_scale));
            end
            AR_MUL2:
            begin
                work_next = PROD_W'(work_reg[PROD1_W-1:0]) * PROD_W'(frame_rate);
                rem_next  = '0;
                step_next = STEP_W'(DIV_STEPS - 1);
            end
            AR_DIV:
            begin
                rem_next  = qbit ? GAP_W'(trial - divisor_reg) : trial[GAP_W-1:0];
                work_next = {work_reg[PROD_W-2:0], qbit};
                step_next = step_reg - STEP_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Outputs: saturate the quotient to the speed width
    always_comb
    begin
        rsp.done     = (state_reg == AR_DONE);
        rsp.quotient = (|work_reg[PROD_W-1:SPEED_W]) ? '1 : work_reg[SPEED_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AR_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg    <= diff_next;
        divisor_reg <= divisor_next;
        work_reg    <= work_next;
        rem_reg     <= rem_next;
    end

endmodule

@@ rtl/gfse_checker.sv @@
// Port-level checker for the speed estimator and its bind to the top level.
`include "gap_filled_speed_estimator_unit_defines.svh"

module gfse_checker
    import gfse_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [SPEED_W-1:0] speed_value,
    input logic               has_speed,
    input logic               run_last
);

    logic out_take;
    logic out_hold;

    assign out_take = out_valid && !out_stall;
    assign out_hold = out_valid && out_stall;

    // no new frame is taken while a result run is pending
    `GFSE_ASSERT_IMP(a_busy_while_emit, out_valid, in_stall, "frame taken during result run")

    // a result without speed carries zero
    `GFSE_ASSERT_IMP(a_no_speed_zero, out_valid && !has_speed, speed_value == '0, "stray speed")

    // a run keeps going until its last result is taken
    `GFSE_ASSERT_NXT(a_run_continues, out_take && !run_last, out_valid, "result run ended early")

    // after the last result the run closes
    `GFSE_ASSERT_NXT(a_run_closes, out_take && run_last, !out_valid, "result after run end")

    // a stalled result holds
    `GFSE_ASSERT_NXT(a_stall_holds, out_hold, out_valid && $stable(speed_value), "result moved")

endmodule

bind gap_filled_speed_estimator_unit gfse_checker u_gfse_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the gap-filled speed estimator: directed and random frame streams.
module testbench;
    import gfse_pkg::*;

    // The run stops here even if results never come; a correct run needs a
    // small fraction of it.
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Settling time for a frame inside the block, with slack beyond its multiply and divide steps.
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_REPORTS   = 10;

    // One speed result as the block should emit it.
    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               has;
        logic               last;
    } speed_result_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [POS_W-1:0]     position   = '0;
    logic                 present    = 1'b0;
    logic                 series_end = 1'b0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [SPEED_W-1:0]   speed_value;
    logic                 has_speed;
    logic                 run_last;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = CFG_PIXEL_SCALE;
    logic [CFG_W-1:0]     cfg_data   = '0;

    // Tracker state kept alongside the block, plus its copy of the registers.
    logic [POS_W-1:0]     ref_pos   = '0;
    logic                 ref_ok    = 1'b0;
    logic [GAP_W-1:0]     gap_count = '0;
    logic [SCALE_W-1:0]   scale_q   = SCALE_RESET;
    logic [RATE_W-1:0]    rate_q    = RATE_RESET;

    // Speeds predicted for accepted frames, oldest first.
    speed_result_t pending_speeds[$];

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    gap_filled_speed_estimator_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .position    (position),
        .present     (present),
        .series_end  (series_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .speed_value (speed_value),
        .has_speed   (has_speed),
        .run_last    (run_last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: stall at random with the rate of the current phase.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Compare every result transaction with the oldest predicted speed.
    always @(posedge clk)
    begin
        speed_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_speeds.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: speed %h has %b last %b",
                             speed_value, has_speed, run_last);
            end
            else
            begin
                want = pending_speeds.pop_front();
                if (speed_value !== want.speed || has_speed !== want.has
                    || run_last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: want %h/%b/%b got %h/%b/%b",
                                 want.speed, want.has, want.last,
                                 speed_value, has_speed, run_last);
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Advance the tracker by one accepted frame and queue the speeds it causes.
    task automatic estimate_frame(input logic [POS_W-1:0] pos, input logic pres,
                                  input logic ends);
        logic [63:0]        span;
        logic [63:0]        product;
        logic [63:0]        quot;
        logic [SPEED_W-1:0] speed;
        speed_result_t      tail;
        int                 emitted;
        int                 i;
        begin
            emitted = 0;
            if (pres)
            begin
                // No reference yet: the frame measures distance zero.
                span = '0;
                if (ref_ok)
                    span = (pos >= ref_pos) ? 64'(pos - ref_pos) : 64'(ref_pos - pos);
                product = span * 64'(scale_q) * 64'(rate_q);
                quot    = product / (64'(gap_count) + 64'd1);
                speed   = (quot > 64'hFFFF_FFFF) ? '1 : quot[SPEED_W-1:0];
                // Backfill every missing frame with the same speed, then this one.
                for (i = 0; i <= int'(gap_count); i++)
                    pending_speeds.push_back('{speed: speed, has: 1'b1, last: 1'b0});
                emitted += int'(gap_count) + 1;
                ref_pos   = pos;
                ref_ok    = 1'b1;
                gap_count = '0;
            end
            else if (gap_count == MAX_GAP)
            begin
                // Gap overflow: drop the reference, flush pending frames and this one.
                for (i = 0; i <= int'(gap_count); i++)
                    pending_speeds.push_back('{speed: '0, has: 1'b0, last: 1'b0});
                emitted += int'(gap_count) + 1;
                gap_count = '0;
                ref_ok    = 1'b0;
            end
            else
            begin
                gap_count = gap_count + 1'b1;
            end
            if (ends)
            begin
                // Series end: flush what is still pending without a speed.
                for (i = 0; i < int'(gap_count); i++)
                    pending_speeds.push_back('{speed: '0, has: 1'b0, last: 1'b0});
                emitted += int'(gap_count);
                gap_count = '0;
                ref_ok    = 1'b0;
                ref_pos   = '0;
            end
            if (emitted > 0)
            begin
                tail      = pending_speeds.pop_back();
                tail.last = 1'b1;
                pending_speeds.push_back(tail);
            end
        end
    endtask

    // Offer one frame, idling first at the phase's rate, and hold it until taken.
    task automatic send_frame(input logic [POS_W-1:0] pos, input logic pres,
                              input logic ends);
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid   <= 1'b1;
            position   <= pos;
            present    <= pres;
            series_end <= ends;
            do
                @(posedge clk);
            while (in_stall);
            estimate_frame(pos, pres, ends);
        end
    endtask

    // Hold off new frames until every predicted speed has arrived.
    task automatic hold_until_drained();
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (pending_speeds.size() != 0);
        end
    endtask

    // Drain, then let a frame that causes no result finish inside the block.
    task automatic wait_idle();
        begin
            hold_until_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        begin
            wait_idle();
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            cfg_we <= 1'b0;
            if (idx == CFG_PIXEL_SCALE)
                scale_q = data[SCALE_W-1:0];
            else
                rate_q = data[RATE_W-1:0];
        end
    endtask

    task automatic set_rate(input logic [RATE_W-1:0] rate);
        begin
            write_reg(CFG_FRAME_RATE, {{(CFG_W-RATE_W){1'b0}}, rate});
        end
    endtask

    // Reset registers: first sample, saturation, backfill, leading gaps, series ends.
    task automatic test_basic_tracking();
        begin
            send_idle_pct = 0;
            stall_pct     = 0;
            send_frame(13'd0, 1'b1, 1'b0);       // first sample, position zero
            send_frame(13'd8191, 1'b1, 1'b0);    // widest jump saturates
            send_frame(13'd8191, 1'b1, 1'b0);    // standing still
            send_frame(13'd8000, 1'b1, 1'b0);
            send_frame(13'd5555, 1'b0, 1'b0);
            send_frame(13'd2730, 1'b0, 1'b0);
            send_frame(13'd8100, 1'b1, 1'b0);    // divide by three, rounds down
            send_frame(13'd0, 1'b0, 1'b1);       // missing frame ends the series
            send_frame(13'd0, 1'b0, 1'b0);       // leading missing frames
            send_frame(13'd0, 1'b0, 1'b0);
            send_frame(13'd4096, 1'b1, 1'b0);
            send_frame(13'd4000, 1'b1, 1'b1);    // present frame ends the series
            send_frame(13'd4095, 1'b1, 1'b0);    // reference forgotten
            send_frame(13'd0, 1'b0, 1'b1);
        end
    endtask

    // Register extremes, zero frame rate and truncating division.
    task automatic test_config_extremes();
        begin
            write_reg(CFG_PIXEL_SCALE, 24'hFF_FFFF);
            set_rate(10'd1023);
            send_frame(13'd100, 1'b1, 1'b0);
            send_frame(13'd101, 1'b1, 1'b0);
            write_reg(CFG_PIXEL_SCALE, 24'd0);
            send_frame(13'd8191, 1'b1, 1'b0);
            write_reg(CFG_PIXEL_SCALE, 24'd1);
            set_rate(10'd0);
            send_frame(13'd0, 1'b1, 1'b0);
            set_rate(10'd1);
            send_frame(13'd8191, 1'b1, 1'b0);
            send_frame(13'd1234, 1'b0, 1'b0);
            send_frame(13'd0, 1'b1, 1'b1);
        end
    endtask

    // Gaps at and beyond the longest the block can bridge.
    task automatic test_gap_overflow();
        int i;
        begin
            write_reg(CFG_PIXEL_SCALE, 24'd65536);
            set_rate(10'd25);
            send_idle_pct = 35;
            stall_pct     = 76;
            send_frame(13'd10, 1'b1, 1'b0);
            // Longest gap that is still bridged.
            for (i = 0; i < int'(MAX_GAP); i++)
                send_frame(13'($urandom_range(0, 8191)), 1'b0, 1'b0);
            send_frame(13'd20, 1'b1, 1'b0);
            // The 64th missing frame overflows the gap.
            for (i = 0; i <= int'(MAX_GAP); i++)
                send_frame(13'($urandom_range(0, 8191)), 1'b0, 1'b0);
            // Reference dropped: distance zero, then the series ends.
            send_frame(13'd4000, 1'b1, 1'b1);
        end
    endtask

    // Random tracks: walks with dropouts, mostly closed by a series end, some noise.
    task automatic test_random_stream(input int n_items, input int idle_pct,
                                      input int stall_in, input logic [SCALE_W-1:0] scale,
                                      input logic [RATE_W-1:0] rate, input bit pause_midway);
        int               sent;
        int               len;
        int               j;
        int               nxt;
        bit               ended;
        bit               paused;
        logic [POS_W-1:0] track_pos;
        begin
            write_reg(CFG_PIXEL_SCALE, scale);
            set_rate(rate);
            send_idle_pct = idle_pct;
            stall_pct     = stall_in;
            sent      = 0;
            paused    = 1'b0;
            track_pos = 13'($urandom_range(0, 8191));
            while (sent < n_items)
            begin
                if (pause_midway && !paused && sent >= n_items / 2)
                begin
                    hold_until_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    // Noise: any field value at all.
                    send_frame(13'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 3) == 0));
                    sent++;
                end
                else
                begin
                    len   = $urandom_range(2, 10);
                    ended = ($urandom_range(0, 3) != 0);
                    for (j = 0; j < len && sent < n_items; j++)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            send_frame(13'($urandom_range(0, 8191)), 1'b0,
                                       ended && j == len - 1);
                        end
                        else
                        begin
                            // Jump anywhere now and then, else take a short step.
                            if ($urandom_range(0, 7) == 0)
                            begin
                                track_pos = 13'($urandom_range(0, 8191));
                            end
                            else
                            begin
                                nxt = int'(track_pos) + int'($urandom_range(0, 400)) - 200;
                                if (nxt < 0)
                                    nxt = 0;
                                if (nxt > 8191)
                                    nxt = 8191;
                                track_pos = 13'(nxt);
                            end
                            send_frame(track_pos, 1'b1, ended && j == len - 1);
                        end
                        sent++;
                    end
                end
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_tracking();
        test_config_extremes();
        test_gap_overflow();
        test_random_stream(8, 0, 0, 24'($urandom_range(0, 65535)),
                           10'($urandom_range(1, 60)), 1'b0);
        test_random_stream(8, 76, 0, 24'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 20)),
                           10'($urandom_range(1, 1023)), 1'b1);
        test_random_stream(8, 0, 76, 24'd1, 10'd1, 1'b0);
        test_random_stream(8, 35, 35, 24'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 20)),
                           10'($urandom_range(1, 1023)), 1'b0);

        wait_idle();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
